FILE: design/tsotm_pkg.sv
// Shared widths, limits and the sequencer state type for the timestamp offset estimator.
package tsotm_pkg;

  localparam int ACQ_W          = 32;
  localparam int DELTA_W        = 33;
  localparam int CORR_W         = 33;
  localparam int SHIFT_W        = 48;
  localparam int FRAC_W         = 16;
  localparam int CFG_W          = 6;
  localparam int CMP_W          = 8;
  localparam int DIST_W         = 50;
  localparam int WINDOW_MAX_DEF = 32;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 88;

  localparam logic [CFG_W-1:0]   WSIZE_RESET = 6'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 48'h8000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_PICK,
    ST_DIV,
    ST_SAT,
    ST_EMIT
  } tsotm_state_t;

endpackage

FILE: design/timestamp_offset_trimmed_mean.sv
// Timestamp offset estimator: sliding window of deltas, iterative trimmed mean.
// n = deltas held, k = round(0.75*n); k = 24 with a full 32-entry window.
// Each pick scans the window memory (one read per cycle); the bit-serial divider then
//   divides the sum of the k picks by k.
// in_tready high only while idle; a finished word waits in the output register. Reset
// (rst_n low, synchronous): window empty, shift zero, window_size 20.
module timestamp_offset_trimmed_mean #(
  parameter int WINDOW_MAX = tsotm_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tsotm_pkg::CFG_W-1:0]        cfg_wr_data,   // window_size
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tsotm_pkg::IN_DATA_W-1:0]    in_tdata,      // acquisition_ms, arrival_ms
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tsotm_pkg::OUT_DATA_W-1:0]   out_tdata      // corrected_ms, shift_q16, pad
);

  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = tsotm_pkg::DELTA_W + CNT_W;
  localparam int DIVD_W = SUM_W + tsotm_pkg::FRAC_W;
  localparam int DCNT_W = $clog2(DIVD_W + 1);
  localparam logic [CNT_W:0]  WMAX_C  = (CNT_W+1)'(WINDOW_MAX);
  localparam logic [DIVD_W-1:0] POS_LIM = DIVD_W'(tsotm_pkg::SHIFT_MAX);
  localparam logic [DIVD_W-1:0] NEG_LIM = DIVD_W'({1'b0, tsotm_pkg::SHIFT_MIN});

  tsotm_pkg::tsotm_state_t state_r, state_nxt;

  logic [tsotm_pkg::CFG_W-1:0]          wsize_r;
  logic signed [tsotm_pkg::DELTA_W-1:0] mem [WINDOW_MAX];
  logic [CNT_W-1:0]                     fill_r;
  logic [SLOT_W-1:0]                    oldest_r;
  logic signed [tsotm_pkg::SHIFT_W-1:0] shift_r;
  logic [tsotm_pkg::ACQ_W-1:0]          acq_r;
  logic signed [tsotm_pkg::DELTA_W-1:0] delta_r;
  logic [CNT_W-1:0]                     n_r;
  logic [CNT_W-1:0]                     k_r;
  logic [CNT_W-1:0]                     picks_r;
  logic [WINDOW_MAX-1:0]                taken_r;
  logic signed [SUM_W-1:0]              sum_r;

  // scan pipeline: issue, read data, distance, compare
  logic [CNT_W-1:0]                     iss_r;
  logic                                 v1_r;
  logic [SLOT_W-1:0]                    slot1_r;
  logic signed [tsotm_pkg::DELTA_W-1:0] rdata_r;
  logic                                 v2_r;
  logic [SLOT_W-1:0]                    slot2_r;
  logic signed [tsotm_pkg::DELTA_W-1:0] val2_r;
  logic [tsotm_pkg::DIST_W-1:0]         dist2_r;
  logic                                 found_r;
  logic [SLOT_W-1:0]                    best_slot_r;
  logic signed [tsotm_pkg::DELTA_W-1:0] best_val_r;
  logic [tsotm_pkg::DIST_W-1:0]         best_dist_r;

  // serial divider
  logic [DIVD_W-1:0]                    quo_r;
  logic [CNT_W-1:0]                     rem_r;
  logic [DCNT_W-1:0]                    dcnt_r;
  logic                                 neg_r;

  logic                                 out_tvalid_r;
  logic [tsotm_pkg::OUT_DATA_W-1:0]     out_tdata_r;

  logic                                 emit_go;
  logic                                 scan_done;

  // effective window size, clamped to 1..WINDOW_MAX
  logic [tsotm_pkg::CMP_W-1:0] cfg_ext;
  logic [CNT_W-1:0]            w_eff;
  always_comb begin
    cfg_ext = tsotm_pkg::CMP_W'(wsize_r);
    if (cfg_ext == '0) begin
      w_eff = CNT_W'(1);
    end else if (cfg_ext > tsotm_pkg::CMP_W'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(cfg_ext);
    end
  end

  // push: drop oldest entries so the new delta fits
  logic [CNT_W-1:0]  fill_adj;
  logic [CNT_W:0]    old_sum;
  logic [SLOT_W-1:0] oldest_adj;
  logic [CNT_W:0]    wr_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [CNT_W-1:0]  n_new;
  logic [CNT_W+1:0]  k_tmp;
  always_comb begin
    if (fill_r >= w_eff) begin
      old_sum  = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(fill_r - w_eff + CNT_W'(1));
      fill_adj = w_eff - CNT_W'(1);
    end else begin
      old_sum  = (CNT_W+1)'(oldest_r);
      fill_adj = fill_r;
    end
    if (old_sum >= WMAX_C) old_sum = old_sum - WMAX_C;
    oldest_adj = old_sum[SLOT_W-1:0];
    wr_sum = (CNT_W+1)'(oldest_adj) + (CNT_W+1)'(fill_adj);
    if (wr_sum >= WMAX_C) wr_sum = wr_sum - WMAX_C;
    wr_slot = wr_sum[SLOT_W-1:0];
    n_new   = fill_adj + CNT_W'(1);
    k_tmp   = (CNT_W+2)'(n_new) + (CNT_W+2)'(n_new) + (CNT_W+2)'(n_new) + (CNT_W+2)'(2);
  end

  // logical scan index to physical slot
  logic [CNT_W:0]    rd_sum;
  logic [SLOT_W-1:0] rd_slot;
  logic              issue;
  always_comb begin
    rd_sum = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(iss_r);
    if (rd_sum >= WMAX_C) rd_sum = rd_sum - WMAX_C;
    rd_slot = rd_sum[SLOT_W-1:0];
    issue   = (state_r == tsotm_pkg::ST_SCAN) && (iss_r < n_r);
  end

  // distance of the read delta from the previous shift
  logic signed [tsotm_pkg::DIST_W-1:0] diff;
  logic [tsotm_pkg::DIST_W-1:0]        dist_abs;
  always_comb begin
    diff = tsotm_pkg::DIST_W'(signed'({rdata_r, {tsotm_pkg::FRAC_W{1'b0}}}))
         - tsotm_pkg::DIST_W'(shift_r);
    dist_abs = diff[tsotm_pkg::DIST_W-1] ? tsotm_pkg::DIST_W'(-diff)
                                         : tsotm_pkg::DIST_W'(diff);
  end

  // divider step
  logic [CNT_W:0] trial;
  logic           qbit;
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    qbit  = (trial >= (CNT_W+1)'(k_r));
  end

  // saturated shift
  logic [DIVD_W-1:0]                    mag;
  logic signed [tsotm_pkg::SHIFT_W-1:0] shift_sat;
  always_comb begin
    mag = quo_r;
    if (neg_r) begin
      if (mag > NEG_LIM) shift_sat = tsotm_pkg::SHIFT_MIN;
      else               shift_sat = -tsotm_pkg::SHIFT_W'(mag);
    end else begin
      if (mag > POS_LIM) shift_sat = tsotm_pkg::SHIFT_MAX;
      else               shift_sat = tsotm_pkg::SHIFT_W'(mag);
    end
  end

  // corrected time: acquisition plus shift truncated toward zero
  logic [tsotm_pkg::CORR_W-1:0] corrected;
  logic                         round_up;
  always_comb begin
    round_up  = shift_r[tsotm_pkg::SHIFT_W-1] && (|shift_r[tsotm_pkg::FRAC_W-1:0]);
    corrected = {acq_r[tsotm_pkg::ACQ_W-1], acq_r}
              + {shift_r[tsotm_pkg::SHIFT_W-1], shift_r[tsotm_pkg::SHIFT_W-1:tsotm_pkg::FRAC_W]}
              + tsotm_pkg::CORR_W'(round_up);
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == tsotm_pkg::ST_IDLE);
    emit_go   = (state_r == tsotm_pkg::ST_EMIT) && (!out_tvalid_r || out_tready);
    scan_done = (iss_r == n_r) && !v1_r && !v2_r;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsotm_pkg::ST_IDLE: if (in_tvalid) state_nxt = tsotm_pkg::ST_PUSH;
      tsotm_pkg::ST_PUSH: state_nxt = tsotm_pkg::ST_SCAN;
      tsotm_pkg::ST_SCAN: if (scan_done) state_nxt = tsotm_pkg::ST_PICK;
      tsotm_pkg::ST_PICK: begin
        if (picks_r + CNT_W'(1) == k_r) state_nxt = tsotm_pkg::ST_DIV;
        else                           state_nxt = tsotm_pkg::ST_SCAN;
      end
      tsotm_pkg::ST_DIV:  if (dcnt_r == DCNT_W'(1)) state_nxt = tsotm_pkg::ST_SAT;
      tsotm_pkg::ST_SAT:  state_nxt = tsotm_pkg::ST_EMIT;
      tsotm_pkg::ST_EMIT: if (emit_go) state_nxt = tsotm_pkg::ST_IDLE;
      default:            state_nxt = tsotm_pkg::ST_IDLE;
    endcase
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == tsotm_pkg::ST_PUSH) mem[wr_slot] <= delta_r;
    rdata_r <= mem[rd_slot];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsotm_pkg::ST_IDLE;
      wsize_r      <= tsotm_pkg::WSIZE_RESET;
      fill_r       <= '0;
      oldest_r     <= '0;
      shift_r      <= '0;
      out_tvalid_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      iss_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) wsize_r <= cfg_wr_data;
      // output word: load on emit, clear once taken
      if (emit_go) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r && !taken_r[slot1_r];
      if (issue) iss_r <= iss_r + CNT_W'(1);
      case (state_r)
        tsotm_pkg::ST_PUSH: begin
          oldest_r <= oldest_adj;
          fill_r   <= n_new;
          iss_r    <= '0;
        end
        tsotm_pkg::ST_PICK: iss_r <= '0;
        tsotm_pkg::ST_SAT:  shift_r <= shift_sat;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    slot1_r <= rd_slot;
    slot2_r <= slot1_r;
    val2_r  <= rdata_r;
    dist2_r <= dist_abs;
    // best-so-far compare; ties go to the smaller delta
    if (v2_r && (!found_r || dist2_r < best_dist_r ||
                 (dist2_r == best_dist_r && val2_r < best_val_r))) begin
      found_r     <= 1'b1;
      best_slot_r <= slot2_r;
      best_val_r  <= val2_r;
      best_dist_r <= dist2_r;
    end
    case (state_r)
      tsotm_pkg::ST_IDLE: begin
        acq_r   <= in_tdata[tsotm_pkg::ACQ_W-1:0];
        delta_r <= tsotm_pkg::DELTA_W'(signed'(in_tdata[2*tsotm_pkg::ACQ_W-1:tsotm_pkg::ACQ_W]))
                 - tsotm_pkg::DELTA_W'(signed'(in_tdata[tsotm_pkg::ACQ_W-1:0]));
      end
      tsotm_pkg::ST_PUSH: begin
        n_r     <= n_new;
        k_r     <= k_tmp[CNT_W+1:2];
        picks_r <= '0;
        taken_r <= '0;
        sum_r   <= '0;
        found_r <= 1'b0;
      end
      tsotm_pkg::ST_PICK: begin
        sum_r   <= sum_r + SUM_W'(best_val_r);
        taken_r[best_slot_r] <= 1'b1;
        picks_r <= picks_r + CNT_W'(1);
        found_r <= 1'b0;
        // load the divider with |sum| * 2^16 on every pick; the last pick's load is divided
        neg_r   <= sum_r[SUM_W-1] ^ best_val_r[tsotm_pkg::DELTA_W-1] ?
                   ((sum_r + SUM_W'(best_val_r)) < 0) : sum_r[SUM_W-1];
        quo_r   <= {((sum_r + SUM_W'(best_val_r)) < 0) ?
                    SUM_W'(-(sum_r + SUM_W'(best_val_r))) :
                    SUM_W'(sum_r + SUM_W'(best_val_r)),
                    {tsotm_pkg::FRAC_W{1'b0}}};
        rem_r   <= '0;
        dcnt_r  <= DCNT_W'(DIVD_W);
      end
      tsotm_pkg::ST_DIV: begin
        rem_r  <= qbit ? CNT_W'(trial - (CNT_W+1)'(k_r)) : CNT_W'(trial);
        quo_r  <= {quo_r[DIVD_W-2:0], qbit};
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      tsotm_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_tdata_r <= tsotm_pkg::OUT_DATA_W'({shift_r, corrected});
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
